>>> rtl/kms_pkg.sv
// Shared types, constants and keymap tables for the keyboard matrix scanner.
// No dependencies.
`default_nettype none
package kms_pkg;

  localparam int unsigned ROWS    = 8;
  localparam int unsigned COLUMNS = 17;
  localparam int unsigned COL_W   = 5;
  localparam int unsigned ROW_W   = 3;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

  // Rows of the modifier column
  localparam int unsigned SHIFT_ROW_A = 1;
  localparam int unsigned SHIFT_ROW_B = 2;
  localparam int unsigned FN_ROW      = 7;

  // Special key codes
  localparam logic [7:0] K_SPEC  = 8'h80;
  localparam logic [7:0] K_SHIFT = K_SPEC | 8'h60;
  localparam logic [7:0] K_CTRL  = K_SPEC | 8'h62;
  localparam logic [7:0] K_ALT   = K_SPEC | 8'h63;
  localparam logic [7:0] K_NONE  = 8'h00;

  typedef logic [7:0] code_t;

  // What one row lane found
  typedef struct packed {
    logic  emit;
    code_t code;
  } lane_res_t;

  localparam code_t MAP_PLAIN [ROWS][COLUMNS] = '{
    '{8'h00,8'h71,8'h77,8'h65,8'h72,8'h75,8'h69,8'h6F,8'h00,8'h00,8'h00,8'h70,
      8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h09,8'hE4,8'hC3,8'h74,8'h79,8'h5D,8'hC7,8'h00,8'h08,8'h00,8'h5B,
      8'h00,8'h00,8'h00,8'h00,8'hE0},
    '{8'h00,8'h61,8'h73,8'h64,8'h66,8'h6A,8'h6B,8'h6C,8'h00,8'h00,8'h00,8'h3B,
      8'h00,8'h00,8'h00,8'hCE,8'hE0},
    '{8'h00,8'h00,8'h5C,8'hC4,8'h67,8'h68,8'hC6,8'h00,8'h20,8'h00,8'hE3,8'h27,
      8'h00,8'h00,8'h00,8'h80,8'h00},
    '{8'h00,8'h7A,8'h78,8'h63,8'h76,8'h6D,8'h2C,8'h2E,8'hE5,8'h0A,8'h00,8'h5C,
      8'h00,8'h00,8'h00,8'h80,8'h00},
    '{8'h00,8'h00,8'h00,8'h00,8'h62,8'h6E,8'h00,8'h00,8'h00,8'h00,8'h00,8'h2F,
      8'h00,8'h00,8'h00,8'h80,8'h00},
    '{8'hE2,8'h60,8'h00,8'h00,8'h35,8'h36,8'h3D,8'hC8,8'h08,8'hC9,8'h00,8'h2D,
      8'h00,8'hC2,8'hD4,8'h00,8'hC1},
    '{8'hC5,8'h31,8'h32,8'h33,8'h34,8'h37,8'h38,8'h39,8'h00,8'h00,8'h00,8'h30,
      8'hCA,8'h00,8'h00,8'h00,8'h00}
  };

  localparam code_t MAP_SHIFT [ROWS][COLUMNS] = '{
    '{8'h00,8'h51,8'h57,8'h45,8'h52,8'h55,8'h49,8'h4F,8'h00,8'h00,8'h00,8'h50,
      8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h09,8'hE4,8'hC3,8'h54,8'h59,8'h7D,8'hC7,8'h00,8'h08,8'h00,8'h7B,
      8'h00,8'h00,8'h00,8'h00,8'hE0},
    '{8'h00,8'h41,8'h53,8'h44,8'h46,8'h4A,8'h4B,8'h4C,8'h00,8'h00,8'h00,8'h3A,
      8'h00,8'h00,8'h00,8'hCE,8'hE0},
    '{8'h00,8'h00,8'h7C,8'hC4,8'h47,8'h48,8'hC6,8'h00,8'h20,8'h00,8'hE3,8'h22,
      8'h00,8'h00,8'h00,8'h80,8'h00},
    '{8'h00,8'h5A,8'h58,8'h43,8'h56,8'h4D,8'h3C,8'h3E,8'hE5,8'h0A,8'h00,8'h7C,
      8'h00,8'h00,8'h00,8'h80,8'h00},
    '{8'h00,8'h00,8'h00,8'h00,8'h42,8'h4E,8'h00,8'h00,8'h00,8'h00,8'h00,8'h3F,
      8'h00,8'h00,8'h00,8'h80,8'h00},
    '{8'hE2,8'h60,8'h00,8'h00,8'h25,8'h5E,8'h3D,8'hC8,8'h08,8'hC9,8'h00,8'h5F,
      8'h00,8'hC2,8'hD4,8'h00,8'hC1},
    '{8'hC5,8'h21,8'h40,8'h23,8'h24,8'h26,8'h2A,8'h28,8'h00,8'h00,8'h00,8'h29,
      8'hCA,8'h00,8'h00,8'h00,8'h00}
  };

  // Fn layer is sparse: only a handful of positions carry a code
  function automatic code_t fn_map(input logic [ROW_W-1:0] row,
                                   input logic [COL_W-1:0] col);
    code_t res;
    res = K_NONE;
    case ({row, col})
      {3'd2, 5'd15}: res = 8'hCF;
      {3'd3, 5'd15}: res = 8'h80;
      {3'd4, 5'd15}: res = 8'hCD;
      {3'd5, 5'd15}: res = 8'h0D;
      {3'd6, 5'd13}: res = 8'hCC;
      {3'd6, 5'd16}: res = 8'hCB;
      default:       res = K_NONE;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

>>> rtl/keyboard_matrix_scanner_core.sv
// Keyboard matrix scanner: each tick's results are registered in the result buffer.
// A tick yields 1 to 8 results, one per cycle from the result buffer while out_stall is low;
// a new tick is taken in the cycle its predecessor's last result leaves.
// Synchronous active-low reset clears all key bits and the column counter.
// Depends on kms_pkg, kms_lane, kms_merge.
`default_nettype none
module keyboard_matrix_scanner_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_row_levels,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [4:0]      out_scanned_column,
  output logic            out_key_valid,
  output logic [7:0]      out_key_code,
  output logic            out_last
);

  logic [kms_pkg::ROWS-1:0]  kp_r [kms_pkg::COLUMNS];
  logic [kms_pkg::COL_W-1:0] col_r, col_nxt;
  logic [kms_pkg::ROWS-1:0]  now;
  logic [kms_pkg::ROWS-1:0]  prev;
  logic                      shift_held, fn_held, buf_full, accept;
  kms_pkg::lane_res_t        lanes [kms_pkg::ROWS];

  assign now    = ~in_row_levels;
  assign prev   = kp_r[col_r];
  assign in_stall = buf_full && !(out_last && !out_stall);
  assign accept   = in_valid && !in_stall;

  // While the modifier column itself is scanned, its shift bits come from the live row levels
  assign shift_held = (col_r == kms_pkg::LAST_COL) ?
    (now[kms_pkg::SHIFT_ROW_A] | now[kms_pkg::SHIFT_ROW_B]) :
    (kp_r[kms_pkg::COLUMNS-1][kms_pkg::SHIFT_ROW_A] |
     kp_r[kms_pkg::COLUMNS-1][kms_pkg::SHIFT_ROW_B]);
  assign fn_held = kp_r[kms_pkg::COLUMNS-1][kms_pkg::FN_ROW];

  assign col_nxt = (col_r == kms_pkg::LAST_COL) ? '0 : col_r + 1'b1;

  for (genvar r = 0; r < kms_pkg::ROWS; r++) begin : g_lane
    kms_lane #(.ROW(r)) u_lane (
      .col         (col_r),
      .now_pressed (now[r]),
      .prev_pressed(prev[r]),
      .shift_held  (shift_held),
      .fn_held     (fn_held),
      .res         (lanes[r])
    );
  end

  kms_merge u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (accept),
    .load_col          (col_r),
    .lanes             (lanes),
    .full              (buf_full),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_scanned_column(out_scanned_column),
    .out_key_valid     (out_key_valid),
    .out_key_code      (out_key_code),
    .out_last          (out_last)
  );

  // Key matrix and column counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      for (int c = 0; c < kms_pkg::COLUMNS; c++) kp_r[c] <= '0;
    end else if (accept) begin
      col_r        <= col_nxt;
      kp_r[col_r]  <= now;
    end
  end

endmodule
`default_nettype wire

>>> rtl/kms_lane.sv
// One row lane: edge detect for a key and keymap selection.
// Depends on kms_pkg.
`default_nettype none
module kms_lane #(
  parameter int unsigned ROW = 0
) (
  input  wire logic [kms_pkg::COL_W-1:0] col,
  input  wire logic                      now_pressed,
  input  wire logic                      prev_pressed,
  input  wire logic                      shift_held,
  input  wire logic                      fn_held,
  output kms_pkg::lane_res_t             res
);

  kms_pkg::code_t plain;
  logic           silent;

  assign plain  = kms_pkg::MAP_PLAIN[ROW][col];
  assign silent = (plain == kms_pkg::K_NONE) || (plain == kms_pkg::K_SHIFT) ||
                  (plain == kms_pkg::K_CTRL) || (plain == kms_pkg::K_ALT);

  // New press of a key that types something
  always_comb begin
    res.emit = !silent && now_pressed && !prev_pressed;
    if (shift_held) begin
      res.code = kms_pkg::MAP_SHIFT[ROW][col];
    end else if (fn_held) begin
      res.code = kms_pkg::fn_map(kms_pkg::ROW_W'(ROW), col);
    end else begin
      res.code = plain;
    end
  end

endmodule
`default_nettype wire

>>> rtl/kms_merge.sv
// Result buffer: holds the lanes' findings for one tick and issues them
// lowest row first. Depends on kms_pkg.
`default_nettype none
module kms_merge (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      load,
  input  wire logic [kms_pkg::COL_W-1:0] load_col,
  input  wire kms_pkg::lane_res_t        lanes [kms_pkg::ROWS],
  output logic                           full,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [4:0]                     out_scanned_column,
  output logic                           out_key_valid,
  output logic [7:0]                     out_key_code,
  output logic                           out_last
);

  logic                      full_r, full_nxt;
  logic [kms_pkg::ROWS-1:0]  mask_r, mask_nxt;
  kms_pkg::code_t            codes_r [kms_pkg::ROWS];
  logic [kms_pkg::COL_W-1:0] col_r;
  logic [kms_pkg::ROWS-1:0]  mask_rest;
  kms_pkg::code_t            sel_code;
  logic                      out_done;

  // Lowest pending row
  always_comb begin
    sel_code = kms_pkg::K_NONE;
    for (int i = kms_pkg::ROWS - 1; i >= 0; i--) begin
      if (mask_r[i]) sel_code = codes_r[i];
    end
  end

  assign mask_rest          = mask_r & (mask_r - 1'b1);
  assign full               = full_r;
  assign out_valid          = full_r;
  assign out_scanned_column = col_r;
  assign out_key_valid      = |mask_r;
  assign out_key_code       = sel_code;
  assign out_last           = (mask_rest == '0);
  assign out_done           = full_r && !out_stall;

  // Buffer control
  always_comb begin
    full_nxt = full_r;
    mask_nxt = mask_r;
    if (out_done) begin
      mask_nxt = mask_rest;
      if (out_last) full_nxt = 1'b0;
    end
    if (load) begin
      full_nxt = 1'b1;
      for (int i = 0; i < kms_pkg::ROWS; i++) mask_nxt[i] = lanes[i].emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      mask_r <= '0;
    end else begin
      full_r <= full_nxt;
      mask_r <= mask_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      col_r <= load_col;
      for (int i = 0; i < kms_pkg::ROWS; i++) codes_r[i] <= lanes[i].code;
    end
  end

  a_nokey_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (full_r && !out_key_valid) |-> out_last)
    else $error("empty result not marked last");
  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_done && !out_last) |=> (full_r && mask_r != '0))
    else $error("results lost within a tick");
  a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> full_r)
    else $error("buffer not filled after load");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!full_r || (out_done && out_last)))
    else $error("buffer overwritten");

endmodule
`default_nettype wire
